/* design/b2da_pkg.sv */
// Package for the binary to decimal ASCII converter.
// Holds the pipeline stage record and the field widths; no dependencies.
package b2da_pkg;

  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned TDATA_IN_W  = 32;
  localparam int unsigned TDATA_OUT_W = 88;  // 4 + 10*8 = 84, padded to 88

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 8'h30;
  localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;  // ceil(2^35 / 10)

  // One stage of the digit chain: what is left to convert plus the
  // digits peeled so far, least significant in slot 0.
  typedef struct packed {
    logic [VALUE_W-1:0]                 rest;
    logic [NUM_DIGITS-1:0][3:0]         digits;
    logic [NUM_DIGITS-1:0]              sig;
  } b2da_stage_t;

endpackage

/* design/b2da_cell.sv */
// One cell of the divide-by-ten chain: peels one decimal digit per stage.
// Depends on b2da_pkg.
module b2da_cell import b2da_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  b2da_stage_t in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output b2da_stage_t out_data
);

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   quot_x10;
  logic [VALUE_W-1:0]   rem_full;
  b2da_stage_t          stage_next;

  // quotient by reciprocal multiply, exact for every 32-bit value
  assign prod     = {{VALUE_W{1'b0}}, in_data.rest} * {{VALUE_W{1'b0}}, RECIP_TEN};
  assign quot     = {3'b000, prod[2*VALUE_W-1:35]};
  assign quot_x10 = {quot[VALUE_W-4:0], 3'b000} + {quot[VALUE_W-2:0], 1'b0};
  assign rem_full = in_data.rest - quot_x10;

  always_comb begin
    stage_next = in_data;
    stage_next.rest = quot;
    stage_next.digits[IDX] = rem_full[3:0];
    // the units digit always counts; higher ones only while value remains
    stage_next.sig[IDX] = (IDX == 0) ? 1'b1 : (in_data.rest != '0);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

/* design/b2da_format.sv */
// Output stage: counts significant digits, left-justifies them as ASCII
// and holds the result register. Depends on b2da_pkg.
module b2da_format import b2da_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  b2da_stage_t            in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [TDATA_OUT_W-1:0] out_data
);

  logic [COUNT_W-1:0]               count;
  logic [NUM_DIGITS-1:0][CHAR_W-1:0] chars;
  logic [TDATA_OUT_W-1:0]           data_next;

  // sig bits are contiguous from slot 0, so the count is the popcount
  always_comb begin
    count = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (in_data.sig[i]) begin
        count = COUNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    logic [COUNT_W-1:0] src;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      src = count - COUNT_W'(k + 1);
      if (COUNT_W'(k) < count) begin
        chars[k] = ASCII_ZERO + {4'b0000, in_data.digits[src]};
      end else begin
        chars[k] = '0;
      end
    end
  end

  assign data_next = {4'b0000, chars, count};

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

/* design/binary_to_decimal_ascii.sv */
// Top level of the binary to decimal ASCII converter: ten divide cells
// in a row and an output formatting stage. Depends on b2da_pkg,
// b2da_cell and b2da_format.
//
//   port group   dir  payload (low bit first)
//   s_axis_*     in   tdata: number[31:0]
//   m_axis_*     out  tdata: digit_count[3:0], char_0 .. char_9 (8 each), 4 zero bits
//
// One transaction per cycle sustained while the output is not stalled; each
// number is registered in ten digit cells, then the format register. Each
// cell has its own valid and per-stage ready, so a stall at the output fills
// bubbles before it reaches the input. Reset clears the valid bits only.
module binary_to_decimal_ascii import b2da_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // number[31:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata    // digit_count, char_0..char_9, pad
);

  logic        valid [NUM_DIGITS+1];
  logic        ready [NUM_DIGITS+1];
  b2da_stage_t data  [NUM_DIGITS+1];

  always_comb begin
    data[0] = '0;
    data[0].rest = s_axis_tdata;
  end
  assign valid[0]      = s_axis_tvalid;
  assign s_axis_tready = ready[0];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    b2da_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .in_data   (data[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .out_data  (data[i+1])
    );
  end

  b2da_format u_format (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid[NUM_DIGITS]),
    .in_ready  (ready[NUM_DIGITS]),
    .in_data   (data[NUM_DIGITS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[3:0] != 4'd0) && (m_axis_tdata[3:0] <= 4'd10))
    else $error("digit count out of range");

  a_lead_digit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[11:4] >= 8'h30) && (m_axis_tdata[11:4] <= 8'h39))
    else $error("leading character is not a digit");

  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[3:0] != 4'd10)) |-> (m_axis_tdata[83:76] == 8'h00))
    else $error("last slot filled with fewer than ten digits");

  a_tenth_cell: assert property (@(posedge clk) disable iff (rst)
    valid[NUM_DIGITS] |-> (data[NUM_DIGITS].rest == '0))
    else $error("value left over after ten digits");

endmodule
